// File: sv/rcd_pkg.sv
// Shared types, constants and helpers of the RTMP chunk deframer.
// Used by rtmp_chunk_deframer; has no dependencies.
package rcd_pkg;

	localparam int CHAN_W        = 6;
	localparam int NUM_CHAN      = 64;
	localparam int CS_W          = 17;
	localparam int HDR_MAX       = 11;
	localparam int CNT_W         = 4;
	localparam int PADDR_W       = 3;
	localparam logic [CS_W-1:0] CHUNK_SIZE_RESET = 17'd128;
	localparam logic REG_CHUNK_SIZE = 1'b0;

	// Per-channel message header context, one store entry per channel.
	typedef struct packed {
		logic [23:0] ts;
		logic [23:0] len;
		logic [7:0]  mtype;
		logic [31:0] stream;
		logic [23:0] done;
	} ctx_t;

	localparam int CTX_W = $bits(ctx_t);

	// Header bytes that follow the basic header byte for each format.
	function automatic logic [CNT_W-1:0] hdr_need(input logic [1:0] fmt);
		logic [CNT_W-1:0] n;
		case (fmt)
			2'd0:    n = 4'd11;
			2'd1:    n = 4'd7;
			2'd2:    n = 4'd3;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	// Payload bytes the chunk carries: min(remaining body, size limit).
	function automatic logic [CS_W-1:0] chunk_rem(input ctx_t c, input logic [CS_W-1:0] lim);
		logic [23:0] left;
		logic [CS_W-1:0] r;
		left = (c.len > c.done) ? (c.len - c.done) : 24'd0;
		r = (left < {7'd0, lim}) ? left[CS_W-1:0] : lim;
		return r;
	endfunction

endpackage

// File: sv/rcd_in_if.sv
// Input channel of the deframer: one raw stream byte per beat.
// Depends on nothing.
interface rcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// File: sv/rcd_out_if.sv
// Output channel of the deframer: one tagged payload byte per beat.
// Depends on nothing.
interface rcd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic [5:0]  channel;
	logic [7:0]  message_type;
	logic [23:0] timestamp;
	logic [31:0] stream_id;
	logic [23:0] message_length;
	logic [23:0] byte_offset;
	logic        last_of_message;

	modport source (output valid, output payload_byte, output channel, output message_type,
		output timestamp, output stream_id, output message_length, output byte_offset,
		output last_of_message, input ready);
	modport sink (input valid, input payload_byte, input channel, input message_type,
		input timestamp, input stream_id, input message_length, input byte_offset,
		input last_of_message, output ready);
endinterface

// File: sv/rtmp_chunk_deframer.sv
// Top level of the RTMP chunk deframer: header parser, channel context store
// and output register. Depends on rcd_pkg, rcd_in_if, rcd_out_if and rcd_ram.
//
//   channel   dir   beat content
//   in_ch     in    in_byte: one raw chunk stream byte
//   out_ch    out   payload byte tagged with its message header and offset
//   apb       cfg   register 0, selected by paddr[2] = 0: chunk_size (17 bits)
//
// One byte is taken every cycle unless out_ch stalls; each beat goes through the parser
// and the per-channel context read-modify-write. A payload byte appears on
// out_ch in the cycle after its beat. The context store is read on each basic
// header byte that switches to another channel; the active channel's context
// lives in registers. Reset clears the context through 64 valid bits at once,
// so no clearing pass is needed.
// A stall on out_ch holds in_ch only while the output register is full.
module rtmp_chunk_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	rcd_in_if.sink                      in_ch,
	rcd_out_if.source                   out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rcd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import rcd_pkg::*;

	localparam logic [1:0] PH_BASIC  = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;
	localparam logic [1:0] PH_START  = 2'd3;

	logic [CS_W-1:0]   cs_q, lim_q, rem_q, lim_now;
	logic [1:0]        phase_q, phase_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d, need_q, need_d;
	logic [7:0]        hb_q [HDR_MAX];
	logic [7:0]        hb_w [HDR_MAX];
	logic [CHAN_W-1:0] act_q, act_d;
	logic [CS_W-1:0]   rem_d, lim_d;
	ctx_t              ctx_q, ctx_d, eff, ram_rd;
	logic              pend_q, pend_d, rdv_q;
	logic [NUM_CHAN-1:0] vld_q;
	logic              wr_en, rd_en, emit, last_w;
	logic              in_fire, in_rdy;
	logic [23:0]       off_w;
	logic              out_valid_q;

	assign in_rdy = !out_valid_q || out_ch.ready;
	assign in_ch.ready = in_rdy;
	assign in_fire = in_ch.valid && in_rdy;
	assign lim_now = (cs_q == '0) ? {{(CS_W-1){1'b0}}, 1'b1} : cs_q;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CHUNK_SIZE) ? {{(32-CS_W){1'b0}}, cs_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= CHUNK_SIZE_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_CHUNK_SIZE) begin
			cs_q <= pwdata[CS_W-1:0];
		end
	end

	// Context of the active channel: fresh store data right after a load.
	assign eff = pend_q ? (rdv_q ? ram_rd : '0) : ctx_q;

	// Parser for one beat.
	always_comb begin
		logic [1:0] ph;
		logic [CS_W-1:0] rem_w;
		ctx_t c;
		logic [CNT_W-1:0] cnt_n;
		ph = phase_q;
		rem_w = rem_q;
		c = eff;
		cnt_n = cnt_q + 4'd1;
		phase_d = phase_q;
		cnt_d = cnt_q;
		need_d = need_q;
		act_d = act_q;
		rem_d = rem_q;
		lim_d = lim_q;
		pend_d = 1'b0;
		wr_en = 1'b0;
		rd_en = 1'b0;
		emit = 1'b0;
		last_w = 1'b0;
		off_w = eff.done;
		for (int i = 0; i < HDR_MAX; i++) begin
			hb_w[i] = hb_q[i];
		end
		if (in_fire) begin
			// A chunk with no message header starts here, on its first byte.
			if (ph == PH_START) begin
				rem_w = chunk_rem(c, lim_q);
				if (rem_w == '0) begin
					c.done = '0;
					wr_en = 1'b1;
					ph = PH_BASIC;
				end else begin
					ph = PH_BODY;
				end
			end
			case (ph)
				PH_BASIC: begin
					act_d = in_ch.in_byte[5:0];
					need_d = hdr_need(in_ch.in_byte[7:6]);
					cnt_d = '0;
					lim_d = lim_now;
					phase_d = (need_d == '0) ? PH_START : PH_HEADER;
					if (in_ch.in_byte[5:0] != act_q) begin
						rd_en = 1'b1;
						pend_d = 1'b1;
					end
				end
				PH_HEADER: begin
					hb_w[cnt_q] = in_ch.in_byte;
					cnt_d = cnt_n;
					if (cnt_n >= need_q) begin
						if (need_q >= 4'd3) begin
							c.ts = {hb_w[0], hb_w[1], hb_w[2]};
						end
						if (need_q >= 4'd6) begin
							c.len = {hb_w[3], hb_w[4], hb_w[5]};
							c.done = '0;
						end
						if (need_q > 4'd6) begin
							c.mtype = hb_w[6];
						end
						if (need_q == 4'd11) begin
							c.stream = {hb_w[10], hb_w[9], hb_w[8], hb_w[7]};
						end
						rem_w = chunk_rem(c, lim_now);
						if (rem_w == '0) begin
							c.done = '0;
							phase_d = PH_BASIC;
						end else begin
							phase_d = PH_BODY;
						end
						rem_d = rem_w;
						wr_en = 1'b1;
						cnt_d = '0;
					end
				end
				default: begin
					// Body byte.
					emit = 1'b1;
					off_w = c.done;
					c.done = c.done + 24'd1;
					if (c.done >= c.len) begin
						last_w = 1'b1;
						c.done = '0;
						rem_w = '0;
					end else begin
						rem_w = (rem_w != '0) ? rem_w - 1'b1 : '0;
					end
					rem_d = rem_w;
					phase_d = (rem_w == '0) ? PH_BASIC : PH_BODY;
					wr_en = 1'b1;
				end
			endcase
		end
		ctx_d = c;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BASIC;
			cnt_q <= '0;
			need_q <= '0;
			act_q <= '0;
			rem_q <= '0;
			lim_q <= CHUNK_SIZE_RESET;
			pend_q <= 1'b0;
			rdv_q <= 1'b0;
			vld_q <= '0;
			ctx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			need_q <= need_d;
			act_q <= act_d;
			rem_q <= rem_d;
			lim_q <= lim_d;
			pend_q <= pend_d;
			ctx_q <= ctx_d;
			if (rd_en) begin
				rdv_q <= vld_q[in_ch.in_byte[5:0]];
			end
			if (wr_en) begin
				vld_q[act_q] <= 1'b1;
			end
			if (in_fire && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Header byte capture and output payload register.
	always_ff @(posedge clk) begin
		for (int i = 0; i < HDR_MAX; i++) begin
			hb_q[i] <= hb_w[i];
		end
		if (in_fire && emit) begin
			out_ch.payload_byte <= in_ch.in_byte;
			out_ch.channel <= act_q;
			out_ch.message_type <= eff.mtype;
			out_ch.timestamp <= eff.ts;
			out_ch.stream_id <= eff.stream;
			out_ch.message_length <= eff.len;
			out_ch.byte_offset <= off_w;
			out_ch.last_of_message <= last_w;
		end
	end

	assign out_ch.valid = out_valid_q;

	// Channel context store.
	rcd_ram #(
		.WIDTH(CTX_W),
		.DEPTH(NUM_CHAN)
	) u_ctx_ram (
		.clk(clk),
		.we(wr_en),
		.waddr(act_q),
		.wdata(ctx_d),
		.re(rd_en),
		.raddr(in_ch.in_byte[5:0]),
		.rdata(ram_rd)
	);

endmodule

// File: sv/rcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
